[rtl/sorted_series_linear_interpolator_assert.svh]
// Assertion macros used by the checks in the top-level interpolator.
`ifndef SORTED_SERIES_LINEAR_INTERPOLATOR_ASSERT_SVH
`define SORTED_SERIES_LINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ssli_pkg.sv]
package ssli_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_GAP   = 2'd2;

  localparam logic [31:0] MaxGapReset = 32'd2560;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic              busy;
    logic [CountW-1:0] count;
  } stat_t;

endpackage

[rtl/ssli_ram.sv]
module ssli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/ssli_front.sv]
module ssli_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssli_pkg::in_t in_data_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output ssli_pkg::in_t item_o
);

  ssli_pkg::in_t slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    fill_q;
  logic          push, pop;

  assign in_ready_o   = (fill_q != 2'd2);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = slot_q[rptr_q];
  // Drop unused kind codes here so the back end sees only real work.
  assign push = in_valid_i && in_ready_o && (in_data_i.kind != ssli_pkg::KIND_UNUSED);
  assign pop  = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= in_data_i;
  end

endmodule

[rtl/ssli_back.sv]
module ssli_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  ssli_pkg::in_t  item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssli_pkg::out_t out_data_o,
  output ssli_pkg::stat_t stat_o
);

  localparam int unsigned AW = ssli_pkg::AddrW;
  localparam int unsigned CW = ssli_pkg::CountW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_BND  = 4'd3;
  localparam logic [3:0] S_RDA  = 4'd4;
  localparam logic [3:0] S_RDB  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_ADD  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]         state_q;
  logic [CW-1:0]      count_q, lo_q, len_q;
  logic [31:0]        max_gap_q, t_q, ta_q, tb_q;
  logic signed [31:0] va_q, vb_q;
  logic [32:0]        rem_q;
  logic [16:0]        quo_q;
  logic [4:0]         step_q;
  logic signed [50:0] prod_q;
  ssli_pkg::out_t     res_q;

  logic [CW-1:0]      half, mid;
  logic [AW-1:0]      raddr;
  logic [31:0]        time_rd, val_rd, dt;
  logic [32:0]        trial;
  logic               take;
  logic               wr_en;
  logic signed [32:0] vdiff;

  assign half  = len_q >> 1;
  assign mid   = lo_q + half;
  assign dt    = tb_q - ta_q;
  assign trial = (step_q == 5'd0) ? rem_q : {rem_q[31:0], 1'b0};
  assign take  = (trial >= {1'b0, dt});
  assign vdiff = {vb_q[31], vb_q} - {va_q[31], va_q};

  assign item_ready_o = (state_q == S_IDLE);
  assign wr_en = item_valid_i && item_ready_o && (item_i.kind == ssli_pkg::KIND_APPEND)
                 && (count_q < CW'(ssli_pkg::TableDepth));

  always_comb begin
    case (state_q)
      S_BND:   raddr = AW'(lo_q - CW'(1));
      S_RDA:   raddr = lo_q[AW-1:0];
      default: raddr = mid[AW-1:0];
    endcase
  end

  ssli_ram #(.Width(32), .Depth(ssli_pkg::TableDepth)) u_time_ram (
    .clk_i, .we_i(wr_en), .waddr_i(count_q[AW-1:0]), .wdata_i(item_i.sample_time),
    .raddr_i(raddr), .rdata_o(time_rd)
  );

  ssli_ram #(.Width(32), .Depth(ssli_pkg::TableDepth)) u_value_ram (
    .clk_i, .we_i(wr_en), .waddr_i(count_q[AW-1:0]), .wdata_i(item_i.sample_value),
    .raddr_i(raddr), .rdata_o(val_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      max_gap_q <= ssli_pkg::MaxGapReset;
    end else begin
      if (cfg_we_i) max_gap_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            case (item_i.kind)
              ssli_pkg::KIND_CLEAR:  count_q <= '0;
              ssli_pkg::KIND_APPEND: if (wr_en) count_q <= count_q + CW'(1);
              ssli_pkg::KIND_QUERY:  state_q <= S_SRCH;
              default: ;
            endcase
          end
        end
        S_SRCH:  state_q <= (len_q == '0) ? S_BND : S_SCMP;
        S_SCMP:  state_q <= S_SRCH;
        S_BND: begin
          if (lo_q < CW'(2) || lo_q >= count_q) state_q <= S_OUT;
          else state_q <= S_RDA;
        end
        S_RDA:   state_q <= S_RDB;
        S_RDB:   state_q <= S_CHK;
        S_CHK: begin
          if (!(ta_q < t_q && t_q <= tb_q) || dt > max_gap_q) state_q <= S_OUT;
          else state_q <= S_DIV;
        end
        S_DIV:   if (step_q == 5'd16) state_q <= S_MUL;
        S_MUL:   state_q <= S_ADD;
        S_ADD:   state_q <= S_OUT;
        S_OUT:   if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        t_q   <= item_i.sample_time;
        lo_q  <= '0;
        len_q <= count_q;
      end
      S_SCMP: begin
        if (time_rd < t_q) begin
          lo_q  <= mid + CW'(1);
          len_q <= len_q - half - CW'(1);
        end else begin
          len_q <= half;
        end
      end
      S_BND:   res_q <= '{interp_value: '0, status: ssli_pkg::STATUS_RANGE};
      S_RDA: begin
        ta_q <= time_rd;
        va_q <= val_rd;
      end
      S_RDB: begin
        tb_q <= time_rd;
        vb_q <= val_rd;
      end
      S_CHK: begin
        rem_q  <= {1'b0, t_q - ta_q};
        quo_q  <= '0;
        step_q <= '0;
        if (ta_q < t_q && t_q <= tb_q && dt > max_gap_q) begin
          res_q.status <= ssli_pkg::STATUS_GAP;
        end
      end
      S_DIV: begin
        rem_q  <= take ? trial - {1'b0, dt} : trial;
        quo_q  <= {quo_q[15:0], take};
        step_q <= step_q + 5'd1;
      end
      S_MUL:   prod_q <= $signed({1'b0, quo_q}) * vdiff;
      S_ADD: begin
        res_q.interp_value <= va_q + prod_q[47:16];
        res_q.status       <= ssli_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;
  assign stat_o      = '{busy: (state_q != S_IDLE), count: count_q};

endmodule

[rtl/sorted_series_linear_interpolator.sv]
// Sorted-series linear interpolator.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one item per
// transfer: clear the table, append a (time, value) sample, or query a time.
// Only queries produce a result transfer on out_valid_o/out_ready_i; it holds
// the interpolated value, or zero with a status code (outside usable range,
// or gap wider than max_gap). max_gap is written through cfg_we_i/cfg_wdata_i.
// A two-entry queue in front of the execution engine takes items while the
// engine is busy; the engine handles one item at a time.
// Clear and append retire while the engine stays idle. A query runs a bisection
// in which each step is a RAM read then a compare (up to 13 steps at a full
// table), fetches and checks the bracketing pair (S_BND, S_RDA, S_RDB, S_CHK),
// runs the restoring fraction divider for 17 quotient bits, then multiply, add
// and the result register. Search and pair reads share the single read port of
// the time RAM, and the divider produces one quotient bit per cycle.
// Reset empties the table and queue and loads max_gap with 2560; no RAM
// clearing pass is needed since only written entries are ever read.
// When the receiver stalls, the result holds in the output register and
// the engine waits; the queue keeps taking items until it fills.
module sorted_series_linear_interpolator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssli_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssli_pkg::out_t out_data_o
);

`include "sorted_series_linear_interpolator_assert.svh"

  logic            item_valid, item_ready;
  ssli_pkg::in_t   item;
  ssli_pkg::stat_t stat;
  logic            count_in_range, fail_result, clear_xfer;

  // Front: accept transfers and queue them for the engine.
  ssli_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .item_valid_o(item_valid), .item_ready_i(item_ready), .item_o(item)
  );

  // Back: table update, search, divide, multiply, result register.
  ssli_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .item_valid_i(item_valid), .item_ready_o(item_ready), .item_i(item),
    .out_valid_o, .out_ready_i, .out_data_o, .stat_o(stat)
  );

  assign count_in_range = (stat.count <= ssli_pkg::CountW'(ssli_pkg::TableDepth));
  assign fail_result    = out_valid_o && (out_data_o.status != ssli_pkg::STATUS_OK);
  assign clear_xfer     = item_valid && item_ready && (item.kind == ssli_pkg::KIND_CLEAR);

  // Table fill never passes capacity.
  `SSLI_ASSERT_NOW(a_count_cap, 1'b1, count_in_range, "entry count past capacity")
  // A result only comes from a busy engine.
  `SSLI_ASSERT_NOW(a_out_busy, out_valid_o, stat.busy, "result while engine idle")
  // Failed lookups report zero.
  `SSLI_ASSERT_NOW(a_zero_fail, fail_result, out_data_o.interp_value == '0, "nonzero value")
  // A clear taken by the idle engine empties the table.
  `SSLI_ASSERT_NEXT(a_clear, clear_xfer, stat.count == '0, "clear did not empty table")

endmodule

[verif/sorted_series_linear_interpolator_tb.sv]
module sorted_series_linear_interpolator_tb;

  // Cycles to let queued clears/appends retire after the last result.
  localparam int unsigned SETTLE = 80;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  logic  [31:0] cfg_wdata_i;
  logic  in_valid_i;
  logic  in_ready_o;
  ssli_pkg::in_t  in_data_i;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  ssli_pkg::out_t out_data_o;

  sorted_series_linear_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the sample table, its fill level and the gap register.
  logic [31:0]        table_times  [ssli_pkg::TableDepth];
  logic signed [31:0] table_values [ssli_pkg::TableDepth];
  int unsigned        table_len;
  logic [31:0]        gap_limit;

  // Answers predicted for accepted queries, oldest first.
  ssli_pkg::out_t pending_answers[$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned send_idle;
  int unsigned recv_idle;

  // Lower-bound bisection, then interpolate between the bracketing pair.
  function automatic ssli_pkg::out_t answer_query(logic [31:0] t);
    int unsigned lo, len, half, mid;
    logic [31:0] ta, tb, dt, t_off, frac;
    logic [63:0] num;
    longint va, vb, prod, q;
    ssli_pkg::out_t r;
    r.interp_value = '0;
    r.status       = ssli_pkg::STATUS_RANGE;
    lo  = 0;
    len = table_len;
    while (len > 0) begin
      half = len / 2;
      mid  = lo + half;
      if (table_times[mid] < t) begin
        lo  = mid + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    // Edge of table: found entry is 0 or 1, or none qualifies.
    if (lo < 2 || lo >= table_len) return r;
    ta = table_times[lo-1];
    tb = table_times[lo];
    // Out-of-order data can leave a pair that does not bracket t.
    if (!(ta < t && t <= tb)) return r;
    dt = tb - ta;
    if (dt > gap_limit) begin
      r.status = ssli_pkg::STATUS_GAP;
      return r;
    end
    t_off = t - ta;
    num   = {32'd0, t_off} << 16;
    frac  = 32'(num / {32'd0, dt});
    va    = longint'(table_values[lo-1]);
    vb    = longint'(table_values[lo]);
    prod  = longint'(frac) * (vb - va);
    q     = prod >>> 16;  // arithmetic shift floors toward minus infinity
    r.interp_value = 32'(va + q);
    r.status       = ssli_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic void predict_item(ssli_pkg::in_t it);
    case (it.kind)
      ssli_pkg::KIND_CLEAR: table_len = 0;
      ssli_pkg::KIND_APPEND: begin
        // Drop appends once the table is full.
        if (table_len < ssli_pkg::TableDepth) begin
          table_times[table_len]  = it.sample_time;
          table_values[table_len] = it.sample_value;
          table_len++;
        end
      end
      ssli_pkg::KIND_QUERY:
        pending_answers.insert(pending_answers.size(), answer_query(it.sample_time));
      default: ;
    endcase
  endfunction

  function automatic ssli_pkg::in_t make_item(logic [1:0] k, logic [31:0] t,
                                              logic [31:0] v);
    ssli_pkg::in_t it;
    it.kind         = k;
    it.sample_time  = t;
    it.sample_value = v;
    return it;
  endfunction

  // Offer one item; hold valid and payload until the transfer.
  task automatic send_item(logic [1:0] k, logic [31:0] t, logic [31:0] v);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= make_item(k, t, v);
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(make_item(k, t, v));
    if (k != ssli_pkg::KIND_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted answer has come back.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_gap(logic [31:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    gap_limit    = value;
  endtask

  // Receiver side: stall at random on every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    ssli_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d status %0d",
                   out_data_o.interp_value, out_data_o.status);
      end else begin
        want = pending_answers.pop_front();
        if (want.interp_value !== out_data_o.interp_value ||
            want.status !== out_data_o.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     want.interp_value, want.status,
                     out_data_o.interp_value, out_data_o.status);
        end
      end
    end
  end

  // Extremes of every field, each kind, and the status cases.
  task automatic test_directed;
    send_item(ssli_pkg::KIND_QUERY,  32'd150, 32'd0);         // empty table
    send_item(ssli_pkg::KIND_APPEND, 32'd100, 32'h8000_0000);
    send_item(ssli_pkg::KIND_APPEND, 32'd200, 32'h7FFF_FFFF);
    send_item(ssli_pkg::KIND_APPEND, 32'd300, -32'sd5);
    send_item(ssli_pkg::KIND_APPEND, 32'd300, 32'd10);
    send_item(ssli_pkg::KIND_APPEND, 32'd5000, 32'd0);
    send_item(ssli_pkg::KIND_APPEND, 32'hFFFF_FFFF, 32'd1);
    send_item(ssli_pkg::KIND_QUERY,  32'd0, 32'hFFFF_FFFF);  // found entry 0
    send_item(ssli_pkg::KIND_QUERY,  32'd150, 32'd0);        // found entry 1
    send_item(ssli_pkg::KIND_QUERY,  32'd250, 32'd0);        // max to small value
    send_item(ssli_pkg::KIND_QUERY,  32'd201, 32'd0);
    send_item(ssli_pkg::KIND_QUERY,  32'd300, 32'd0);        // duplicate times
    send_item(ssli_pkg::KIND_QUERY,  32'd1000, 32'd0);       // gap too wide
    send_item(ssli_pkg::KIND_QUERY,  32'hFFFF_FFFF, 32'd0);
    send_item(ssli_pkg::KIND_UNUSED, 32'd250, 32'd7);        // ignored kind
    send_item(ssli_pkg::KIND_APPEND, 32'd10, 32'd99);        // out of order
    send_item(ssli_pkg::KIND_QUERY,  32'd5, 32'd0);
    send_item(ssli_pkg::KIND_QUERY,  32'd250, 32'd0);
    send_item(ssli_pkg::KIND_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ssli_pkg::KIND_QUERY,  32'd250, 32'd0);        // cleared table
  endtask

  // Gap register at both extremes over the same table.
  task automatic test_gap_extremes;
    logic [31:0] gaps [2];
    gaps[0] = 32'd0;
    gaps[1] = 32'hFFFF_FFFF;
    foreach (gaps[g]) begin
      write_gap(gaps[g]);
      send_item(ssli_pkg::KIND_CLEAR,  32'd0, 32'd0);
      send_item(ssli_pkg::KIND_APPEND, 32'd0, 32'h8000_0000);
      send_item(ssli_pkg::KIND_APPEND, 32'd1, 32'h8000_0000);
      send_item(ssli_pkg::KIND_APPEND, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
      send_item(ssli_pkg::KIND_APPEND, 32'hFFFF_FFFF, 32'h8000_0000);
      send_item(ssli_pkg::KIND_QUERY,  32'd2, 32'd0);
      send_item(ssli_pkg::KIND_QUERY,  32'h8000_0000, 32'd0);
      send_item(ssli_pkg::KIND_QUERY,  32'hFFFF_FFFE, 32'd0);
      send_item(ssli_pkg::KIND_QUERY,  32'hFFFF_FFFF, 32'd0);
    end
  endtask

  // Mostly clean series with random content; some noise and broken order.
  task automatic test_random(int unsigned n_items);
    int unsigned stop_at, len, nq, i, idx;
    logic [31:0] t, step;
    logic [1:0]  k;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8) begin
        send_item(ssli_pkg::KIND_CLEAR, $urandom, $urandom);
        len = $urandom_range(2, 40);
        t   = $urandom;
        for (i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0, 1:    step = 32'd0;
            2:       step = $urandom;                 // may wrap: out of order
            3:       step = $urandom_range(2561, 20000);
            default: step = $urandom_range(1, 2560);
          endcase
          t = t + step;
          send_item(ssli_pkg::KIND_APPEND, t, $urandom);
        end
        nq = $urandom_range(3, 12);
        for (i = 0; i < nq; i++) begin
          idx = $urandom_range(0, table_len - 1);
          send_item(ssli_pkg::KIND_QUERY, table_times[idx] - $urandom_range(0, 3000),
                    $urandom);
        end
      end else begin
        k = 2'($urandom_range(3));
        send_item(k, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    table_len   = 0;
    gap_limit   = ssli_pkg::MaxGapReset;
    mismatches  = 0;
    items_sent  = 0;
    send_idle   = 22;
    recv_idle   = 57;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_gap_extremes();

    write_gap(32'd2560);
    test_random(430);
    send_idle = 57;
    recv_idle = 22;
    write_gap($urandom_range(0, 30000));
    test_random(430);
    send_idle = 0;
    recv_idle = 0;
    write_gap(32'hFFFF_FFFF);
    test_random(430);

    drain();
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
